// ===== src/efc_pkg.sv =====
`default_nettype none
package efc_pkg;

  // Framing constants
  localparam logic [7:0] START_MARK = 8'hAA;
  localparam logic [7:0] ESC_MARK   = 8'hFF;
  localparam logic [3:0] SEQ_MASK   = 4'hF;

  // Input opcodes
  localparam logic [1:0] OP_ENCODE    = 2'd0;
  localparam logic [1:0] OP_DECODE    = 2'd1;
  localparam logic [1:0] OP_CHUNK_END = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NO_START = 2'd0;
  localparam logic [1:0] ERR_NO_LEN   = 2'd1;
  localparam logic [1:0] ERR_RAN_OUT  = 2'd2;

  // Receive phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_SEQ  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_ESC  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  // Most result words one input word can cause
  localparam int MAX_RES = 5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] b, logic [7:0] idx,
                                  logic [7:0] flen, logic [1:0] err);
    res_t r;
    r.kind          = kind;
    r.out_byte      = b;
    r.payload_index = idx;
    r.frame_length  = flen;
    r.error_code    = err;
    r.last          = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/escaped_frame_codec_top.sv =====
`default_nettype none
// Byte-stuffed frame codec.
// Input stream (in_*): in_tuser carries the opcode (encode payload byte, decode
// line byte, chunk end); in_tdata carries the byte and the encode/decode
// side fields. Output stream (out_*): one result word per transfer, kind in
// out_tuser, out_tlast set on the final word caused by one input word.
// An accepted word is expanded in the same cycle into a result queue of up
// to five entries; its first result is visible on the next cycle.
// Words that cause no result (most line bytes while decoding) are taken one
// per cycle. A word causing results holds the output until each is taken; the
// next input word is accepted in the cycle its last result is taken, so the
// output port sets the rate.
// Synchronous active-low reset empties the result queue, clears the send
// sequence number and returns the decoder to hunting for a start marker.
// When the receiver stalls, the head result holds and in_tready stays low
// while any result of the current word is queued.
module escaped_frame_codec_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [7:0] data_byte, [8] first_of_frame, [16:9] payload_length,
  // [24:17] receive_capacity, [31:25] zero
  input  wire  [31:0] in_tdata,
  // [1:0] opcode
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [7:0] out_byte, [15:8] payload_index, [23:16] frame_length,
  // [25:24] error_code, [31:26] zero
  output logic [31:0] out_tdata,
  // [1:0] kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);
  import efc_pkg::*;

  // Result queue: entry 0 is the head shown on the output
  res_t       res_r   [MAX_RES];
  res_t       res_nxt [MAX_RES];
  res_t       new_res [MAX_RES];
  logic [2:0] cnt_r, cnt_nxt, new_cnt;

  // Codec state
  logic [3:0] seq_r, seq_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] rlen_r, rlen_nxt;
  logic [7:0] rcnt_r, rcnt_nxt;
  logic [7:0] rlim_r, rlim_nxt;

  logic       acc, take;
  logic [1:0] op;
  logic [7:0] d_byte, plen, cap, dlv_byte, cnt_inc, len_m1;
  logic       first;

  assign op     = in_tuser;
  assign d_byte = in_tdata[7:0];
  assign first  = in_tdata[8];
  assign plen   = in_tdata[16:9];
  assign cap    = in_tdata[24:17];

  assign out_tvalid = (cnt_r != 3'd0);
  assign in_tready  = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);
  assign acc        = in_tvalid && in_tready;
  assign take       = out_tvalid && out_tready;

  assign out_tuser = res_r[0].kind;
  assign out_tlast = res_r[0].last;
  assign out_tdata = {6'd0, res_r[0].error_code, res_r[0].frame_length,
                      res_r[0].payload_index, res_r[0].out_byte};

  assign cnt_inc  = rcnt_r + 8'd1;
  assign len_m1   = (d_byte == 8'd0) ? 8'd0 : d_byte - 8'd1;
  assign dlv_byte = (phase_r == PH_ESC) ? ~d_byte : d_byte;

  // Expand the incoming word into its results and next state
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      new_res[i] = mk_res(KIND_LINE, 8'd0, 8'd0, 8'd0, ERR_NO_START);
    end
    new_cnt   = 3'd0;
    seq_nxt   = seq_r;
    phase_nxt = phase_r;
    rlen_nxt  = rlen_r;
    rcnt_nxt  = rcnt_r;
    rlim_nxt  = rlim_r;
    unique case (op)
      OP_ENCODE: begin
        if (first) begin
          new_res[0] = mk_res(KIND_LINE, START_MARK, 8'd0, 8'd0, ERR_NO_START);
          new_res[1] = mk_res(KIND_LINE, plen + 8'd1, 8'd0, 8'd0, ERR_NO_START);
          new_res[2] = mk_res(KIND_LINE, {4'd0, seq_r & SEQ_MASK}, 8'd0, 8'd0,
                              ERR_NO_START);
          new_cnt    = 3'd3;
          seq_nxt    = (seq_r + 4'd1) & SEQ_MASK;
        end
        if (d_byte == START_MARK || d_byte == ESC_MARK) begin
          new_res[new_cnt]        = mk_res(KIND_LINE, ESC_MARK, 8'd0, 8'd0,
                                           ERR_NO_START);
          new_res[new_cnt + 3'd1] = mk_res(KIND_LINE, ~d_byte, 8'd0, 8'd0,
                                           ERR_NO_START);
          new_cnt                 = new_cnt + 3'd2;
        end else begin
          new_res[new_cnt] = mk_res(KIND_LINE, d_byte, 8'd0, 8'd0, ERR_NO_START);
          new_cnt          = new_cnt + 3'd1;
        end
      end
      OP_DECODE: begin
        unique case (phase_r)
          PH_HUNT: begin
            if (d_byte == START_MARK) phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            rlen_nxt  = len_m1;
            rlim_nxt  = (cap < len_m1) ? cap : len_m1;
            rcnt_nxt  = 8'd0;
            phase_nxt = PH_SEQ;
          end
          PH_SEQ: begin
            if (rlim_r == 8'd0) begin
              new_res[0] = mk_res(KIND_DONE, 8'd0, 8'd0, rlen_r, ERR_NO_START);
              new_cnt    = 3'd1;
              phase_nxt  = PH_DONE;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA, PH_ESC: begin
            if (phase_r == PH_DATA && d_byte == ESC_MARK) begin
              phase_nxt = PH_ESC;
            end else begin
              // deliver one payload byte, close the frame at the limit
              new_res[0] = mk_res(KIND_DATA, dlv_byte, rcnt_r, 8'd0, ERR_NO_START);
              new_cnt    = 3'd1;
              rcnt_nxt   = cnt_inc;
              if (cnt_inc >= rlim_r) begin
                new_res[1] = mk_res(KIND_DONE, 8'd0, 8'd0, rlen_r, ERR_NO_START);
                new_cnt    = 3'd2;
                phase_nxt  = PH_DONE;
              end else begin
                phase_nxt = PH_DATA;
              end
            end
          end
          default: ;
        endcase
      end
      OP_CHUNK_END: begin
        unique case (phase_r)
          PH_HUNT: begin
            new_res[0] = mk_res(KIND_ERROR, 8'd0, 8'd0, 8'd0, ERR_NO_START);
            new_cnt    = 3'd1;
          end
          PH_LEN: begin
            new_res[0] = mk_res(KIND_ERROR, 8'd0, 8'd0, 8'd0, ERR_NO_LEN);
            new_cnt    = 3'd1;
          end
          PH_SEQ: begin
            if (rlim_r == 8'd0) begin
              new_res[0] = mk_res(KIND_DONE, 8'd0, 8'd0, rlen_r, ERR_NO_START);
            end else begin
              new_res[0] = mk_res(KIND_ERROR, 8'd0, 8'd0, 8'd0, ERR_RAN_OUT);
            end
            new_cnt = 3'd1;
          end
          PH_DATA, PH_ESC: begin
            new_res[0] = mk_res(KIND_ERROR, 8'd0, 8'd0, 8'd0, ERR_RAN_OUT);
            new_cnt    = 3'd1;
          end
          default: ;
        endcase
        phase_nxt = PH_HUNT;
        rlen_nxt  = 8'd0;
        rcnt_nxt  = 8'd0;
        rlim_nxt  = 8'd0;
      end
      default: ;
    endcase
    // mark the final result of this word
    for (int i = 0; i < MAX_RES; i++) begin
      new_res[i].last = (3'(i) + 3'd1 == new_cnt);
    end
  end

  // Load a new word's results or advance the queue on a take
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_nxt[i] = res_r[i];
    end
    cnt_nxt = cnt_r;
    if (acc) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_nxt[i] = new_res[i];
      end
      cnt_nxt = new_cnt;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_nxt[i] = res_r[i + 1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_r[i] <= res_nxt[i];
    end
  end

  // Control and codec state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      seq_r   <= 4'd0;
      phase_r <= PH_HUNT;
      rlen_r  <= 8'd0;
      rcnt_r  <= 8'd0;
      rlim_r  <= 8'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        seq_r   <= seq_nxt;
        phase_r <= phase_nxt;
        rlen_r  <= rlen_nxt;
        rcnt_r  <= rcnt_nxt;
        rlim_r  <= rlim_nxt;
      end
    end
  end

  // A header advances the send sequence by one
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == OP_ENCODE && first) |=> (seq_r == $past(seq_r) + 4'd1))
    else $error("send sequence did not advance after a header");

  // A tagged last result is the only one left in the queue
  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (cnt_r == 3'd1))
    else $error("last result is not at the queue tail");

  // While taking payload, the delivered count stays under the limit
  a_count_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA || phase_r == PH_ESC) |-> (rcnt_r < rlim_r))
    else $error("receive count reached limit while taking payload");

  // Chunk end returns the decoder to hunting with cleared counters
  a_chunk_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && op == OP_CHUNK_END) |=>
      (phase_r == PH_HUNT && rcnt_r == 8'd0 && rlim_r == 8'd0))
    else $error("decoder not cleared after chunk end");

endmodule
`default_nettype wire

// ===== test/escaped_frame_codec_top_tb.sv =====
`default_nettype none
module escaped_frame_codec_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efc_pkg::*;

  // Opcode the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles with no accepted word or taken result before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 270;

  // Tracks codec state and holds the result words each accepted word should cause
  class frame_scoreboard;
    res_t       pending_q[$];
    logic [3:0] tx_seq;
    logic [2:0] rx_phase;
    logic [7:0] rx_len;
    logic [7:0] rx_count;
    logic [7:0] rx_limit;
    int         mismatches;
    int         checked;

    function new();
      tx_seq     = 4'd0;
      mismatches = 0;
      checked    = 0;
      close_chunk();
    endfunction

    function void close_chunk();
      rx_phase = PH_HUNT;
      rx_len   = 8'd0;
      rx_count = 8'd0;
      rx_limit = 8'd0;
    endfunction

    function void add(logic [1:0] kind, logic [7:0] b, logic [7:0] idx,
                      logic [7:0] flen, logic [1:0] err);
      res_t r;
      r.kind          = kind;
      r.out_byte      = b;
      r.payload_index = idx;
      r.frame_length  = flen;
      r.error_code    = err;
      r.last          = 1'b0;
      pending_q.push_back(r);
    endfunction

    // Hand one payload byte to the receiver; report done once the limit is hit
    function void deliver(logic [7:0] b);
      add(KIND_DATA, b, rx_count, 8'd0, ERR_NO_START);
      rx_count = rx_count + 8'd1;
      if (rx_count >= rx_limit) begin
        add(KIND_DONE, 8'd0, 8'd0, rx_len, ERR_NO_START);
        rx_phase = PH_DONE;
      end else begin
        rx_phase = PH_DATA;
      end
    endfunction

    function void note_word(logic [1:0] op, logic [31:0] tdata);
      logic [7:0] b;
      logic       first;
      logic [7:0] plen;
      logic [7:0] cap;
      int         n0;
      b     = tdata[7:0];
      first = tdata[8];
      plen  = tdata[16:9];
      cap   = tdata[24:17];
      n0    = pending_q.size();
      case (op)
        OP_ENCODE: begin
          if (first) begin
            add(KIND_LINE, START_MARK, 8'd0, 8'd0, ERR_NO_START);
            add(KIND_LINE, plen + 8'd1, 8'd0, 8'd0, ERR_NO_START);
            add(KIND_LINE, {4'd0, tx_seq & SEQ_MASK}, 8'd0, 8'd0, ERR_NO_START);
            tx_seq = tx_seq + 4'd1;
          end
          if (b == START_MARK || b == ESC_MARK) begin
            add(KIND_LINE, ESC_MARK, 8'd0, 8'd0, ERR_NO_START);
            add(KIND_LINE, ~b, 8'd0, 8'd0, ERR_NO_START);
          end else begin
            add(KIND_LINE, b, 8'd0, 8'd0, ERR_NO_START);
          end
        end
        OP_DECODE: begin
          case (rx_phase)
            PH_HUNT: if (b == START_MARK) rx_phase = PH_LEN;
            PH_LEN: begin
              rx_len   = (b == 8'd0) ? 8'd0 : b - 8'd1;
              rx_limit = (cap < rx_len) ? cap : rx_len;
              rx_count = 8'd0;
              rx_phase = PH_SEQ;
            end
            PH_SEQ: begin
              if (rx_limit == 8'd0) begin
                add(KIND_DONE, 8'd0, 8'd0, rx_len, ERR_NO_START);
                rx_phase = PH_DONE;
              end else begin
                rx_phase = PH_DATA;
              end
            end
            PH_DATA: begin
              if (b == ESC_MARK) rx_phase = PH_ESC;
              else deliver(b);
            end
            PH_ESC: deliver(~b);
            default: ;
          endcase
        end
        OP_CHUNK_END: begin
          case (rx_phase)
            PH_HUNT: add(KIND_ERROR, 8'd0, 8'd0, 8'd0, ERR_NO_START);
            PH_LEN:  add(KIND_ERROR, 8'd0, 8'd0, 8'd0, ERR_NO_LEN);
            PH_SEQ: begin
              if (rx_limit == 8'd0) add(KIND_DONE, 8'd0, 8'd0, rx_len, ERR_NO_START);
              else add(KIND_ERROR, 8'd0, 8'd0, 8'd0, ERR_RAN_OUT);
            end
            PH_DATA, PH_ESC: add(KIND_ERROR, 8'd0, 8'd0, 8'd0, ERR_RAN_OUT);
            default: ;
          endcase
          close_chunk();
        end
        default: ;
      endcase
      if (pending_q.size() > n0) pending_q[pending_q.size() - 1].last = 1'b1;
    endfunction

    function void cmp_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [31:0] tdata, logic last);
      res_t e;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected result word, expected none, got kind %0h data %0h",
                   $time, kind, tdata);
        return;
      end
      e = pending_q.pop_front();
      cmp_field("kind", int'(e.kind), int'(kind));
      cmp_field("out_byte", int'(e.out_byte), int'(tdata[7:0]));
      cmp_field("payload_index", int'(e.payload_index), int'(tdata[15:8]));
      cmp_field("frame_length", int'(e.frame_length), int'(tdata[23:16]));
      cmp_field("error_code", int'(e.error_code), int'(tdata[25:24]));
      cmp_field("last", int'(e.last), int'(last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;
  logic [1:0]  in_tuser = 2'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  frame_scoreboard sb = new();
  bit calm = 1'b0;
  int n_words = 0;
  int n_enc_frames = 0;
  int n_dec_frames = 0;
  int idle_cycles = 0;
  int stall_left = 0;

  escaped_frame_codec_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Record accepted words on both sides
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_word(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
  end

  // Stall the result side in random bursts; no new burst starts in the calm tail
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Abandon the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one word and hold it until accepted, then maybe idle
  task automatic push_word(logic [1:0] op, logic [7:0] b, logic first,
                           logic [7:0] plen, logic [7:0] cap);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, cap, plen, first, b};
    do @(posedge clk); while (!in_tready);
    n_words++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic enc(logic [7:0] b, logic first, logic [7:0] plen);
    push_word(OP_ENCODE, b, first, plen, 8'($urandom));
  endtask

  task automatic dec(logic [7:0] b, logic [7:0] cap);
    push_word(OP_DECODE, b, 1'($urandom), 8'($urandom), cap);
  endtask

  task automatic chunk_end();
    push_word(OP_CHUNK_END, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Payload byte biased toward the two bytes that need escaping
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return START_MARK;
    if (r == 1) return ESC_MARK;
    return 8'($urandom);
  endfunction

  // Encode one frame with random content
  task automatic encode_frame();
    logic [7:0] plen;
    int         nbytes;
    plen = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 254))
                                       : 8'($urandom_range(1, 10));
    nbytes = (plen > 8'd12) ? $urandom_range(1, 12) : int'(plen);
    for (int i = 0; i < nbytes; i++) enc(pick_byte(), i == 0, plen);
    n_enc_frames++;
  endtask

  // Feed one received chunk: noise, a framed payload, maybe cut short, then garbage
  task automatic decode_chunk();
    logic [7:0] line[$];
    logic [7:0] b;
    logic [7:0] len_byte;
    logic [7:0] cap;
    int         real_len;
    int         sent;
    repeat ($urandom_range(0, 2)) line.push_back(8'($urandom));
    line.push_back(START_MARK);
    real_len = $urandom_range(0, 12);
    if ($urandom_range(0, 7) == 0) begin
      len_byte = 8'($urandom);
      cap = 8'($urandom_range(0, 8));
    end else begin
      len_byte = 8'(real_len + 1);
      case ($urandom_range(0, 2))
        0: cap = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(real_len, 255));
        1: cap = 8'($urandom_range(0, real_len));
        default: cap = 8'($urandom);
      endcase
    end
    line.push_back(len_byte);
    line.push_back(8'($urandom));
    for (int i = 0; i < real_len; i++) begin
      b = pick_byte();
      if (b == START_MARK || b == ESC_MARK) begin
        line.push_back(ESC_MARK);
        line.push_back(~b);
      end else begin
        line.push_back(b);
      end
    end
    repeat ($urandom_range(0, 2)) line.push_back(8'($urandom));
    sent = ($urandom_range(0, 4) == 0) ? $urandom_range(0, line.size() - 1) : line.size();
    // The length byte is the only one whose capacity field counts
    for (int i = 0; i < sent; i++) dec(line[i], (line[i] == len_byte) ? cap : 8'($urandom));
    if ($urandom_range(0, 9) != 0) chunk_end();
    n_dec_frames++;
  endtask

  // Scatter loose words: stray line bytes, unused opcodes, bare chunk ends
  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 3))
        0: push_word(OP_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
        1: chunk_end();
        default: dec(8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Decoder corner cases
    chunk_end();                                  // nothing seen: no start marker
    dec(START_MARK, 8'd0); chunk_end();           // marker only: missing length
    dec(START_MARK, 8'd0); dec(8'd0, 8'd255);     // zero length byte
    dec(8'h5A, 8'd0); chunk_end();                // done on sequence byte, then silent end
    dec(START_MARK, 8'd0); dec(8'd1, 8'd255);     // empty payload, cut before sequence
    chunk_end();
    dec(START_MARK, 8'd0); dec(8'd5, 8'd255); chunk_end();   // ran out before sequence
    dec(START_MARK, 8'd0); dec(8'd4, 8'd255); dec(8'h00, 8'd0);
    dec(ESC_MARK, 8'd0); chunk_end();             // ran out right after an escape
    dec(START_MARK, 8'd0); dec(8'd3, 8'd1); dec(8'h01, 8'd0);
    dec(START_MARK, 8'd0);                        // marker inside payload is plain data
    push_word(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 8'hFF);
    dec(8'h12, 8'd0); chunk_end();                // bytes after done are ignored

    // Encoder corner cases: wrapped length byte with escaped first byte, an escaped later byte, two more headers
    enc(START_MARK, 1'b1, 8'd255);
    enc(ESC_MARK, 1'b0, 8'd255);
    enc(8'h00, 1'b1, 8'd1);
    enc(8'hFE, 1'b1, 8'd254);

    // Random mix of frames, chunks and loose words
    while (n_words < RANDOM_WORDS + 30) begin
      if (n_words > RANDOM_WORDS - 30) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: encode_frame();
        9: noise_burst();
        default: decode_chunk();
      endcase
    end
    calm = 1'b1;
    in_tvalid <= 1'b0;

    // Drain results, then give the block time to show anything stray
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d input words: %0d encoded frames, %0d received chunks",
             n_words, n_enc_frames, n_dec_frames);
    $display("checked %0d result words against the predicted stream", sb.checked);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== escaped_frame_codec_top.f =====
src/efc_pkg.sv
src/escaped_frame_codec_top.sv
test/escaped_frame_codec_top_tb.sv
